/* design/sdr_pkg.sv */
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared types and constants for the signed decimal radix sorter.
// ----------------------------------------------------------------------------
package sdr_pkg;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned NBUCKETS = 19;
  localparam int unsigned BKT_W    = 5;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned RECIP_SH = 35;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [2*DATA_W-1:0] entry_t;
  typedef logic [BKT_W-1:0] bucket_t;
  typedef logic [POS_W-1:0] pos_t;

  // bucket of digit zero, negative digits below, positive above
  localparam bucket_t ZERO_BKT = 5'd9;
  // highest digit position of a 32-bit magnitude
  localparam pos_t MAX_POS = 4'd9;
  // n / 10 == (n * RECIP10) >> RECIP_SH for any 32-bit n
  localparam logic [DATA_W-1:0] RECIP10 = 32'hCCCCCCCD;

  // powers of ten used to place each decimal digit
  function automatic logic [DATA_W-1:0] pow10(input pos_t p);
    logic [DATA_W-1:0] r;
    unique case (p)
      4'd0: r = 32'd1;
      4'd1: r = 32'd10;
      4'd2: r = 32'd100;
      4'd3: r = 32'd1000;
      4'd4: r = 32'd10000;
      4'd5: r = 32'd100000;
      4'd6: r = 32'd1000000;
      4'd7: r = 32'd10000000;
      4'd8: r = 32'd100000000;
      default: r = 32'd1000000000;
    endcase
    return r;
  endfunction
endpackage

/* design/signed_decimal_lsd_radix_sort.sv */
// ----------------------------------------------------------------------------
// signed_decimal_lsd_radix_sort
// Loads signed words, sorts them ascending by base-10 LSD radix sort, emits.
// ----------------------------------------------------------------------------
// Loading takes one word per cycle while busy is low, so words may follow back to
// back. The last word starts the sort: it runs P digit passes (P = largest
// digit count, 1 to 10), each a count sweep through one MAX_ITEMS-entry RAM,
// a 19-step prefix pass and a scatter sweep into the other RAM; the two RAMs
// swap roles every pass. Each RAM entry keeps the word beside its magnitude
// divided down to the current digit, so one divide by ten per word per pass is
// enough. The sorted words then leave one per cycle on out_valid, busy staying
// high until the burst is done; the receiver cannot stall them.
module signed_decimal_lsd_radix_sort #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sdr_pkg::word_t     in_value,
  input  logic               in_last_in,
  output logic               out_valid,
  output sdr_pkg::word_t     out_sorted_value,
  output logic               out_last_out,
  output logic               out_overflow
);
  import sdr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CNT  = 3'd1;
  localparam logic [2:0] S_PFX  = 3'd2;
  localparam logic [2:0] S_SCT  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    st_r;
  logic [CW-1:0] cnt_r, idx_r, acc_r;
  pos_t          maxp_r, pass_r;
  logic          drop_r, src_r;
  logic          v1_r, v2_r, last1_r;
  bucket_t       bi_r, bkt_r;
  entry_t        ent_r;
  logic [CW-1:0] cntb_r [NBUCKETS];

  // buffer a and b
  logic          a_we, b_we;
  logic [AW-1:0] a_wa, b_wa, rd_a;
  entry_t        a_wd, b_wd, a_rd, b_rd, s_rd;

  sdr_ram #(.WIDTH(2*DATA_W), .DEPTH(MAX_ITEMS)) u_a (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(rd_a), .rdata(a_rd));
  sdr_ram #(.WIDTH(2*DATA_W), .DEPTH(MAX_ITEMS)) u_b (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(rd_a), .rdata(b_rd));

  logic                acc_in, issue, sweep_done;
  logic [DATA_W-1:0]   in_mag, s_q, q_div;
  logic [2*DATA_W-1:0] q_prod;
  logic [3:0]          s_dig;
  bucket_t             s_bkt;
  pos_t                in_pos;

  assign busy       = (st_r != S_IDLE);
  assign acc_in     = start && !busy;
  assign issue      = (idx_r != cnt_r);
  assign sweep_done = !issue && !v1_r && !v2_r;
  assign rd_a       = idx_r[AW-1:0];

  // incoming magnitude and its highest digit position
  assign in_mag = in_value[DATA_W-1] ? ((~in_value) + 32'd1) : in_value;

  always_comb begin
    in_pos = '0;
    for (int k = 1; k <= int'(MAX_POS); k++) begin
      if (in_mag >= pow10(POS_W'(k))) in_pos = POS_W'(k);
    end
  end

  // digit of the word read from the source buffer
  assign s_rd   = src_r ? b_rd : a_rd;
  assign s_q    = s_rd[DATA_W-1:0];
  assign q_prod = {32'd0, s_q} * {32'd0, RECIP10};
  assign q_div  = DATA_W'(q_prod >> RECIP_SH);
  assign s_dig  = 4'(s_q - ((q_div << 3) + (q_div << 1)));
  assign s_bkt  = s_rd[2*DATA_W-1] ? bucket_t'(ZERO_BKT - bucket_t'(s_dig))
                                   : bucket_t'(ZERO_BKT + bucket_t'(s_dig));

  always_comb begin
    a_we = 1'b0; a_wa = cnt_r[AW-1:0]; a_wd = {in_value, in_mag};
    b_we = 1'b0; b_wa = cntb_r[bkt_r][AW-1:0]; b_wd = ent_r;
    if (st_r == S_IDLE) begin
      a_we = acc_in && (cnt_r != CW'(MAX_ITEMS));
    end else if (st_r == S_SCT && v2_r) begin
      if (src_r) begin
        a_we = 1'b1; a_wa = cntb_r[bkt_r][AW-1:0]; a_wd = ent_r;
      end else b_we = 1'b1;
    end
  end

  assign out_valid        = (st_r == S_OUT) && v1_r;
  assign out_sorted_value = word_t'(s_rd[2*DATA_W-1:DATA_W]);
  assign out_last_out     = out_valid && last1_r;
  assign out_overflow     = drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; idx_r <= '0; acc_r <= '0;
      maxp_r <= '0; pass_r <= '0; drop_r <= 1'b0; src_r <= 1'b0;
      v1_r <= 1'b0; v2_r <= 1'b0; last1_r <= 1'b0;
      bi_r <= '0; bkt_r <= '0; ent_r <= '0;
      for (int i = 0; i < NBUCKETS; i++) cntb_r[i] <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (acc_in) begin
          if (cnt_r != CW'(MAX_ITEMS)) begin
            cnt_r <= cnt_r + CW'(1);
            if (in_pos > maxp_r) maxp_r <= in_pos;
          end else drop_r <= 1'b1;
          if (in_last_in) begin
            idx_r <= '0; pass_r <= '0; st_r <= S_CNT;
          end
        end
        S_CNT, S_SCT: begin
          if (issue) idx_r <= idx_r + CW'(1);
          v1_r <= issue;
          v2_r <= v1_r;
          if (v1_r) begin
            bkt_r <= s_bkt;
            ent_r <= {s_rd[2*DATA_W-1:DATA_W], q_div};
          end
          if (v2_r) cntb_r[bkt_r] <= cntb_r[bkt_r] + CW'(1);
          if (sweep_done) begin
            idx_r <= '0;
            if (st_r == S_CNT) begin
              bi_r <= '0; acc_r <= '0; st_r <= S_PFX;
            end else begin
              src_r <= !src_r;
              for (int i = 0; i < NBUCKETS; i++) cntb_r[i] <= '0;
              if (pass_r == maxp_r) st_r <= S_OUT;
              else begin
                pass_r <= pass_r + POS_W'(1); st_r <= S_CNT;
              end
            end
          end
        end
        S_PFX: begin
          cntb_r[bi_r] <= acc_r;
          acc_r <= acc_r + cntb_r[bi_r];
          if (bi_r == bucket_t'(NBUCKETS - 1)) st_r <= S_SCT;
          else bi_r <= bi_r + bucket_t'(1);
        end
        S_OUT: begin
          if (issue) idx_r <= idx_r + CW'(1);
          v1_r <= issue;
          last1_r <= issue && (idx_r + CW'(1) == cnt_r);
          if (!issue && !v1_r) begin
            st_r <= S_IDLE; idx_r <= '0; cnt_r <= '0; maxp_r <= '0;
            pass_r <= '0; drop_r <= 1'b0; src_r <= 1'b0;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/sdr_ram.sv */
// ----------------------------------------------------------------------------
// sdr_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module sdr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/sdr_checker.sv */
// ----------------------------------------------------------------------------
// sdr_checker
// Port-level checks for the radix sorter.
// ----------------------------------------------------------------------------
module sdr_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last_out,
  input logic out_overflow
);
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_out |-> out_valid) else $error("last without valid");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("word out while idle");
  a_ovf_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && $past(rst_n) |-> $stable(out_overflow))
    else $error("overflow changed in burst");
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_out |=> out_valid) else $error("burst broken");
  a_acc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid) else $error("word out right after accept");
endmodule

bind signed_decimal_lsd_radix_sort sdr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_last_out(out_last_out), .out_overflow(out_overflow));

/* tb/signed_decimal_lsd_radix_sort_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_decimal_lsd_radix_sort_test
// Loads sets of signed words into the sorter, predicts the sorted burst with
// a behavioral digit-bucket sort, and checks every emitted word field by
// field against it. Covers extremes, overflow of capacity and random sets.
// ----------------------------------------------------------------------------
module signed_decimal_lsd_radix_sort_test;
  import sdr_pkg::*;

  localparam int CAP = 64;
  localparam int RADIX = 10;
  localparam int NBKT = 19;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    word_t value;
    logic  last;
    logic  ovf;
  } sorted_word_t;

  class sort_scoreboard;
    word_t        held[$];
    logic         dropped;
    sorted_word_t pending[$];
    int           errors;

    function new();
      dropped = 0;
      errors = 0;
    endfunction

    function int digit_bucket(word_t v, int pos);
      longint x;
      x = v;
      for (int i = 0; i < pos; i++) x = x / RADIX;
      return int'(x % RADIX) + RADIX - 1;
    endfunction

    function int digit_span(word_t v);
      longint x;
      int p;
      x = longint'(v) / RADIX;
      p = 0;
      while (x != 0) begin
        x = x / RADIX;
        p++;
      end
      return p;
    endfunction

    function void note_word(word_t v, logic last);
      int top;
      word_t nxt[$];
      sorted_word_t r;
      if (held.size() < CAP) held = {held, v};
      else dropped = 1;
      if (!last) return;
      top = 0;
      foreach (held[i]) if (digit_span(held[i]) > top) top = digit_span(held[i]);
      for (int p = 0; p <= top; p++) begin
        nxt = {};
        for (int b = 0; b < NBKT; b++)
          foreach (held[i]) if (digit_bucket(held[i], p) == b) nxt = {nxt, held[i]};
        held = nxt;
      end
      foreach (held[i]) begin
        r.value = held[i];
        r.last = (i == held.size() - 1);
        r.ovf = dropped;
        pending = {pending, r};
      end
      held = {};
      dropped = 0;
    endfunction

    function void check_word(sorted_word_t got);
      sorted_word_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %0d/%0b/%0b", $time,
                 got.value, got.last, got.ovf);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value)
        $display("%0t sorted_value: expected %0d, actual %0d", $time, want.value, got.value);
      if (got.last !== want.last)
        $display("%0t last_out: expected %0b, actual %0b", $time, want.last, got.last);
      if (got.ovf !== want.ovf)
        $display("%0t overflow: expected %0b, actual %0b", $time, want.ovf, got.ovf);
      if (got !== want) errors++;
    endfunction
  endclass

  logic  clk = 0;
  logic  rst_n = 0;
  logic  start = 0;
  logic  busy;
  word_t in_value = '0;
  logic  in_last_in = 0;
  logic  out_valid;
  word_t out_sorted_value;
  logic  out_last_out;
  logic  out_overflow;

  sort_scoreboard sb = new();
  longint cycles = 0;
  bit     calm = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  signed_decimal_lsd_radix_sort u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_value(in_value), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_sorted_value(out_sorted_value),
    .out_last_out(out_last_out), .out_overflow(out_overflow)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid)
      sb.check_word({out_sorted_value, out_last_out, out_overflow});
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one word through the handshake, with an optional idle burst first
  task automatic send_word(word_t v, logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1;
    in_value <= v;
    in_last_in <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(v, last);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    int unsigned d;
    longint m;
    d = $urandom_range(0, 10);
    if (d == 10) return word_t'($urandom);
    m = 1;
    repeat (d) m = m * 10;
    return word_t'(($urandom % m) * ($urandom_range(0, 1) ? -1 : 1));
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_word(rand_word(), i == n - 1);
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // extremes and mixed signs
    send_word(32'sd2147483647, 0);
    send_word(32'sh80000000, 0);
    send_word(32'sd0, 0);
    send_word(-32'sd1, 0);
    send_word(32'sd9, 0);
    send_word(-32'sd9, 0);
    send_word(32'sd10, 0);
    send_word(-32'sd10, 0);
    send_word(32'sd1, 0);
    send_word(-32'sd1000000000, 1);
    // single word set
    send_word(32'sd5, 1);
    send_word(32'sh80000000, 1);
    drain();
    // capacity exceeded, the last two words dropped
    for (int i = 0; i < CAP + 2; i++) send_word(rand_word(), i == CAP + 1);
    drain();
    // exactly full
    send_set(CAP);
    // random sets, mostly small
    n = 0;
    while (n < 250) begin
      int k;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, CAP) : $urandom_range(1, 8);
      send_set(k);
      n += k;
    end
    drain();
    calm = 1;
    n = 0;
    while (n < 40) begin
      int k;
      k = $urandom_range(1, 6);
      send_set(k);
      n += k;
    end
    drain();
    if (sb.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
